// File: rtl/rms_pkg.sv
// ----------------------------------------------------------------------------
// Range majority package
// Shared constants, the operation code and the command record that passes
// from the front end through the command queue to the execution back end.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int POSITIONS_DEF  = 1024;
  localparam int VALUE_BITS_DEF = 16;

  localparam int IDX_IN_W  = 10;
  localparam int VAL_IN_W  = 16;
  localparam int CHG_W     = 10;
  localparam int CNT_OUT_W = 11;

  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    OP_WRITE = 3'b001,
    OP_QUERY = 3'b010,
    OP_BAD   = 3'b100
  } rms_op_t;

  typedef struct packed {
    rms_op_t               op;
    logic [IDX_IN_W-1:0]   first;
    logic [IDX_IN_W-1:0]   last;
    logic [VAL_IN_W-1:0]   value;
  } rms_cmd_t;

endpackage

// File: rtl/rms_front.sv
// ----------------------------------------------------------------------------
// Range majority front end
// Accepts items, clips the query end, flags empty ranges, drops writes beyond
// the array and holds the classified command until the queue takes it.
// ----------------------------------------------------------------------------
module rms_front
  import rms_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_cmd,
  input  logic [IDX_IN_W-1:0] in_first_index,
  input  logic [IDX_IN_W-1:0] in_last_index,
  input  logic [VAL_IN_W-1:0] in_new_value,
  input  logic                hold,
  output logic                in_full,
  input  logic                q_full,
  output logic                q_push,
  output rms_cmd_t            q_cmd
);

  localparam logic [31:0] LAST_POS = 32'(POSITIONS - 1);

  logic     front_valid_r, front_valid_nxt;
  rms_cmd_t front_cmd_r, front_cmd_nxt;
  logic     accept;
  logic     keep;
  logic [IDX_IN_W-1:0] last_clip;

  assign in_full = hold | (front_valid_r & q_full);
  assign accept  = in_push & ~in_full;
  assign q_push  = front_valid_r & ~q_full;
  assign q_cmd   = front_cmd_r;

  always_comb begin
    last_clip = in_last_index;
    if (32'(in_last_index) > LAST_POS) begin
      last_clip = IDX_IN_W'(LAST_POS);
    end
    keep                = 1'b1;
    front_cmd_nxt       = front_cmd_r;
    front_cmd_nxt.first = in_first_index;
    front_cmd_nxt.last  = last_clip;
    front_cmd_nxt.value = in_new_value;
    if (in_cmd == CMD_WRITE) begin
      front_cmd_nxt.op = OP_WRITE;
      // Writes beyond the array are dropped without trace.
      keep = (32'(in_first_index) <= LAST_POS);
    end else if (in_first_index > last_clip) begin
      front_cmd_nxt.op = OP_BAD;
    end else begin
      front_cmd_nxt.op = OP_QUERY;
    end

    front_valid_nxt = front_valid_r & q_full;
    if (accept) begin
      front_valid_nxt = keep;
    end else begin
      front_cmd_nxt = front_cmd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_cmd_r <= front_cmd_nxt;
  end

endmodule

// File: rtl/rms_queue.sv
// ----------------------------------------------------------------------------
// Range majority command queue
// A short first-in first-out queue of classified commands between the front
// end and the back end.
// ----------------------------------------------------------------------------
module rms_queue
  import rms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rms_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output rms_cmd_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rms_cmd_t         slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign head    = slots_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/rms_back.sv
// ----------------------------------------------------------------------------
// Range majority back end
// Holds the element store and the vote tree, clears the tree after reset,
// carries out writes and queries and keeps the result register.
// ----------------------------------------------------------------------------
module rms_back
  import rms_pkg::*;
#(
  parameter int POSITIONS  = POSITIONS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  rms_cmd_t             q_head,
  output logic                 q_pop,
  output logic                 clear_busy,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [CHG_W-1:0]     out_changes_needed,
  output logic                 out_majority_found,
  output logic [VAL_IN_W-1:0]  out_majority_value,
  output logic [CNT_OUT_W-1:0] out_majority_count,
  output logic                 out_bad_range
);

  localparam int IDX_W = $clog2(POSITIONS);
  localparam int TW    = IDX_W + 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int VW    = 1 + VALUE_BITS + CNT_W;
  localparam int NODES = 2 * POSITIONS;

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_W_LEAF   = 12'b000000000100,
    S_W_RD     = 12'b000000001000,
    S_W_MERGE  = 12'b000000010000,
    S_Q_LEAF   = 12'b000000100000,
    S_Q_LOAD   = 12'b000001000000,
    S_Q_RD     = 12'b000010000000,
    S_Q_MERGE  = 12'b000100000000,
    S_SCAN     = 12'b001000000000,
    S_SCAN_END = 12'b010000000000,
    S_FIN      = 12'b100000000000
  } rms_state_t;

  // Boyer-Moore merge of two vote entries packed as {valid, candidate, count}.
  function automatic logic [VW-1:0] vote_merge(input logic [VW-1:0] a,
                                               input logic [VW-1:0] b);
    logic                  av, bv;
    logic [VALUE_BITS-1:0] ac, bc;
    logic [CNT_W-1:0]      an, bn;
    logic [VW-1:0]         r;
    av = a[VW-1];
    bv = b[VW-1];
    ac = a[CNT_W +: VALUE_BITS];
    bc = b[CNT_W +: VALUE_BITS];
    an = a[CNT_W-1:0];
    bn = b[CNT_W-1:0];
    if (av == bv && ac == bc) begin
      r = {av, ac, an + bn};
    end else if (an > bn) begin
      r = {av, ac, an - bn};
    end else if (bn > an) begin
      r = {bv, bc, bn - an};
    end else begin
      r = '0;
    end
    return r;
  endfunction

  rms_state_t state_r, state_nxt;
  logic [TW-1:0]         clr_r, clr_nxt;
  logic [IDX_W-1:0]      first_r, first_nxt;
  logic [IDX_W-1:0]      last_r, last_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic                  bad_r, bad_nxt;
  logic [TW-1:0]         lnode_r, lnode_nxt;
  logic [TW-1:0]         rnode_r, rnode_nxt;
  logic [VW-1:0]         acc_l_r, acc_l_nxt;
  logic [VW-1:0]         acc_r_r, acc_r_nxt;
  logic                  merged_r, merged_nxt;
  logic [CNT_W-1:0]      freq_r, freq_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic                  chk_r, chk_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CHG_W-1:0]      out_chg_r, out_chg_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [VAL_IN_W-1:0]   out_val_r, out_val_nxt;
  logic [CNT_OUT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                  out_bad_r, out_bad_nxt;

  logic [VW-1:0]         tree_mem [NODES];
  logic [VW-1:0]         tree_rd_a_r, tree_rd_b_r;
  logic                  tree_we;
  logic [TW-1:0]         tree_waddr, rd_a_addr, rd_b_addr;
  logic [VW-1:0]         tree_wdata;

  logic [VALUE_BITS-1:0] elem_mem [POSITIONS];
  logic [VALUE_BITS-1:0] elem_rd_r;
  logic                  elem_we;
  logic [IDX_W-1:0]      elem_raddr;

  logic [VW-1:0]         merge_w, merge_l, merge_r;
  logic [CNT_W-1:0]      span, half;
  logic                  found;

  assign clear_busy         = (state_r == S_CLEAR);
  assign q_pop              = (state_r == S_IDLE) & ~q_empty;
  assign out_empty          = ~out_valid_r;
  assign out_changes_needed = out_chg_r;
  assign out_majority_found = out_found_r;
  assign out_majority_value = out_val_r;
  assign out_majority_count = out_cnt_r;
  assign out_bad_range      = out_bad_r;

  assign merge_w = lnode_r[0] ? vote_merge(tree_rd_a_r, acc_l_r)
                              : vote_merge(acc_l_r, tree_rd_a_r);
  assign merge_l = lnode_r[0] ? acc_l_r : vote_merge(acc_l_r, tree_rd_a_r);
  assign merge_r = rnode_r[0] ? vote_merge(tree_rd_b_r, acc_r_r) : acc_r_r;

  assign span  = CNT_W'(last_r) - CNT_W'(first_r) + CNT_W'(1);
  assign half  = span >> 1;
  assign found = acc_l_r[VW-1] & (freq_r > half);

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    val_nxt       = val_r;
    bad_nxt       = bad_r;
    lnode_nxt     = lnode_r;
    rnode_nxt     = rnode_r;
    acc_l_nxt     = acc_l_r;
    acc_r_nxt     = acc_r_r;
    merged_nxt    = merged_r;
    freq_nxt      = freq_r;
    ptr_nxt       = ptr_r;
    chk_nxt       = 1'b0;
    out_valid_nxt = out_valid_r & ~out_pop;
    out_chg_nxt   = out_chg_r;
    out_found_nxt = out_found_r;
    out_val_nxt   = out_val_r;
    out_cnt_nxt   = out_cnt_r;
    out_bad_nxt   = out_bad_r;
    tree_we       = 1'b0;
    tree_waddr    = lnode_r >> 1;
    tree_wdata    = merge_w;
    rd_a_addr     = lnode_r ^ TW'(1);
    rd_b_addr     = rnode_r ^ TW'(1);
    elem_we       = 1'b0;
    elem_raddr    = ptr_r;

    unique case (state_r)
      S_CLEAR: begin
        tree_we    = 1'b1;
        tree_waddr = clr_r;
        tree_wdata = '0;
        clr_nxt    = clr_r + TW'(1);
        if (clr_r == {TW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          first_nxt = IDX_W'(q_head.first);
          last_nxt  = IDX_W'(q_head.last);
          val_nxt   = VALUE_BITS'(q_head.value);
          bad_nxt   = 1'b0;
          unique case (q_head.op)
            OP_WRITE: state_nxt = S_W_LEAF;
            OP_QUERY: state_nxt = S_Q_LEAF;
            default: begin
              bad_nxt   = 1'b1;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_W_LEAF: begin
        tree_we    = 1'b1;
        tree_waddr = {1'b1, first_r};
        tree_wdata = {1'b1, val_r, CNT_W'(1)};
        elem_we    = 1'b1;
        acc_l_nxt  = {1'b1, val_r, CNT_W'(1)};
        lnode_nxt  = {1'b1, first_r};
        state_nxt  = S_W_RD;
      end
      S_W_RD: begin
        state_nxt = (lnode_r == TW'(1)) ? S_IDLE : S_W_MERGE;
      end
      S_W_MERGE: begin
        tree_we   = 1'b1;
        acc_l_nxt = merge_w;
        lnode_nxt = lnode_r >> 1;
        state_nxt = S_W_RD;
      end
      S_Q_LEAF: begin
        rd_a_addr  = {1'b1, first_r};
        rd_b_addr  = {1'b1, last_r};
        lnode_nxt  = {1'b1, first_r};
        rnode_nxt  = {1'b1, last_r};
        merged_nxt = (first_r == last_r);
        freq_nxt   = '0;
        state_nxt  = S_Q_LOAD;
      end
      S_Q_LOAD: begin
        acc_l_nxt = tree_rd_a_r;
        acc_r_nxt = tree_rd_b_r;
        state_nxt = S_Q_RD;
      end
      S_Q_RD: begin
        // Once both boundary paths meet, the nodes above add nothing.
        if (merged_r) begin
          ptr_nxt   = first_r;
          state_nxt = acc_l_r[VW-1] ? S_SCAN : S_FIN;
        end else if ((lnode_r >> 1) == (rnode_r >> 1)) begin
          acc_l_nxt  = vote_merge(acc_l_r, acc_r_r);
          merged_nxt = 1'b1;
        end else begin
          state_nxt = S_Q_MERGE;
        end
      end
      S_Q_MERGE: begin
        acc_l_nxt = merge_l;
        acc_r_nxt = merge_r;
        lnode_nxt = lnode_r >> 1;
        rnode_nxt = rnode_r >> 1;
        state_nxt = S_Q_RD;
      end
      S_SCAN: begin
        chk_nxt = 1'b1;
        ptr_nxt = ptr_r + IDX_W'(1);
        if (ptr_r == last_r) begin
          state_nxt = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_bad_nxt   = bad_r;
          if (bad_r) begin
            out_chg_nxt   = '0;
            out_found_nxt = 1'b0;
            out_val_nxt   = '0;
            out_cnt_nxt   = '0;
          end else begin
            out_chg_nxt   = CHG_W'(found ? span - freq_r : half);
            out_found_nxt = found;
            out_val_nxt   = found ? VAL_IN_W'(acc_l_r[CNT_W +: VALUE_BITS]) : '0;
            out_cnt_nxt   = CNT_OUT_W'(freq_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // The element read issued last cycle is compared here.
    if (chk_r && elem_rd_r == acc_l_r[CNT_W +: VALUE_BITS]) begin
      freq_nxt = freq_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      chk_r       <= chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    val_r       <= val_nxt;
    bad_r       <= bad_nxt;
    lnode_r     <= lnode_nxt;
    rnode_r     <= rnode_nxt;
    acc_l_r     <= acc_l_nxt;
    acc_r_r     <= acc_r_nxt;
    merged_r    <= merged_nxt;
    freq_r      <= freq_nxt;
    ptr_r       <= ptr_nxt;
    out_chg_r   <= out_chg_nxt;
    out_found_r <= out_found_nxt;
    out_val_r   <= out_val_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    tree_rd_a_r <= tree_mem[rd_a_addr];
    tree_rd_b_r <= tree_mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[first_r] <= val_r;
    end
    elem_rd_r <= elem_mem[elem_raddr];
  end

endmodule

// File: rtl/range_majority_segment_tree.sv
// ----------------------------------------------------------------------------
// Range majority segment tree
// Array of values with a Boyer-Moore vote tree; answers range majority
// queries with the exact count of the candidate and the changes needed.
// ----------------------------------------------------------------------------
// After reset the block clears all 2*POSITIONS nodes of its vote tree and shows
// full meanwhile. A write then walks up the tree through its single write port;
// a query walks both boundary paths up the tree and then, if a candidate is
// left, counts it over the range, since the element store is read once a cycle,
// one position at a time. Items queue in front while one is worked on, and a
// finished result waits in its own register. POSITIONS must be a power of two.
module range_majority_segment_tree
  import rms_pkg::*;
#(
  parameter int POSITIONS  = POSITIONS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_cmd,
  input  logic [IDX_IN_W-1:0]  in_first_index,
  input  logic [IDX_IN_W-1:0]  in_last_index,
  input  logic [VAL_IN_W-1:0]  in_new_value,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [CHG_W-1:0]     out_changes_needed,
  output logic                 out_majority_found,
  output logic [VAL_IN_W-1:0]  out_majority_value,
  output logic [CNT_OUT_W-1:0] out_majority_count,
  output logic                 out_bad_range
);

  logic     q_push, q_full, q_pop, q_empty, clear_busy;
  rms_cmd_t q_cmd, q_head;

  rms_front #(
    .POSITIONS (POSITIONS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_cmd         (in_cmd),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_new_value   (in_new_value),
    .hold           (clear_busy),
    .in_full        (in_full),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  rms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  rms_back #(
    .POSITIONS  (POSITIONS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .clear_busy         (clear_busy),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_changes_needed (out_changes_needed),
    .out_majority_found (out_majority_found),
    .out_majority_value (out_majority_value),
    .out_majority_count (out_majority_count),
    .out_bad_range      (out_bad_range)
  );

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_bad_range) |-> (out_changes_needed == '0 &&
      !out_majority_found && out_majority_value == '0 && out_majority_count == '0))
    else $error("empty-range result carries non-zero fields");

  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_majority_found) |-> (out_majority_count != '0 && !out_bad_range))
    else $error("majority reported without occurrences");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !q_pop)
    else $error("command taken during tree clearing");

  a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> in_full)
    else $error("input open during tree clearing");

endmodule

// File: verif/range_majority_segment_tree_tb.sv
// ----------------------------------------------------------------------------
// Range majority segment tree testbench
// Loads windows of stored values through write items and asks range
// majority queries inside the written windows and on empty ranges. A local vote
// tree predicts each answer, compared field by field with the popped results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module range_majority_segment_tree_tb
  import rms_pkg::*;
();

  localparam int NPOS = 1024;

  typedef struct {
    logic        cmd;
    logic [9:0]  first;
    logic [9:0]  last;
    logic [15:0] value;
  } request_t;

  typedef struct {
    logic [9:0]  changes;
    logic        found;
    logic [15:0] value;
    logic [10:0] count;
    logic        bad;
  } answer_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] cand;
    logic [10:0] count;
  } vote_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_cmd = 1'b0;
  logic [9:0] in_first_index = '0;
  logic [9:0] in_last_index = '0;
  logic [15:0] in_new_value = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [9:0] out_changes_needed;
  logic out_majority_found;
  logic [15:0] out_majority_value;
  logic [10:0] out_majority_count;
  logic out_bad_range;

  request_t requests[$];
  answer_t answers[$];
  logic [15:0] shadow_store[NPOS];
  vote_t shadow_tree[2*NPOS];
  bit gen_written[NPOS];
  int accepted_items = 0;
  int popped_results = 0;
  int mismatches = 0;
  int stall_left = 0;
  bit stall_done = 0;

  range_majority_segment_tree DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd),
    .in_first_index(in_first_index), .in_last_index(in_last_index),
    .in_new_value(in_new_value),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_changes_needed(out_changes_needed), .out_majority_found(out_majority_found),
    .out_majority_value(out_majority_value), .out_majority_count(out_majority_count),
    .out_bad_range(out_bad_range)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("range_majority_segment_tree_tb NOT OK");
    $finish;
  end

  function automatic vote_t vote_merge(vote_t a, vote_t b);
    vote_t r;
    r = '0;
    if (a.valid == b.valid && a.cand == b.cand) begin
      r = a;
      r.count = a.count + b.count;
    end else if (a.count > b.count) begin
      r = a;
      r.count = a.count - b.count;
    end else if (b.count > a.count) begin
      r = b;
      r.count = b.count - a.count;
    end
    return r;
  endfunction

  // The tree is a heap, so the leaf of a position sits at NPOS plus that position.
  function automatic void store_value(int at, logic [15:0] val);
    int n;
    n = NPOS + at;
    shadow_store[at] = val;
    shadow_tree[n] = '{valid: 1'b1, cand: val, count: 11'd1};
    n = n / 2;
    while (n >= 1) begin
      shadow_tree[n] = vote_merge(shadow_tree[2*n], shadow_tree[2*n+1]);
      n = n / 2;
    end
  endfunction

  // Merge order matters for this vote, so the walk follows the tree recursively.
  function automatic vote_t range_vote(int node, int lo, int hi, int a, int b);
    int mid;
    if (a <= lo && hi <= b) return shadow_tree[node];
    if (b < lo || hi < a) return '0;
    mid = lo + (hi - lo) / 2;
    return vote_merge(range_vote(2*node, lo, mid, a, b),
                      range_vote(2*node+1, mid+1, hi, a, b));
  endfunction

  function automatic answer_t answer_range(int f, int l);
    answer_t r;
    vote_t v;
    int freq;
    int s;
    r = '{default: '0};
    freq = 0;
    if (f > l) begin
      r.bad = 1'b1;
      return r;
    end
    v = range_vote(1, 0, NPOS-1, f, l);
    if (v.valid)
      for (int i = f; i <= l; i++)
        if (shadow_store[i] == v.cand) freq++;
    s = l - f + 1;
    r.found = v.valid && freq > s / 2;
    r.changes = r.found ? 10'(s - freq) : 10'(s / 2);
    r.value = r.found ? v.cand : 16'd0;
    r.count = 11'(freq);
    return r;
  endfunction

  task automatic add_write(int at, logic [15:0] val);
    requests.push_back('{cmd: CMD_WRITE, first: 10'(at), last: 10'($urandom), value: val});
    gen_written[at] = 1;
  endtask

  task automatic add_query(int f, int l);
    requests.push_back('{cmd: CMD_QUERY, first: 10'(f), last: 10'(l),
                         value: 16'($urandom)});
  endtask

  task automatic add_window(int base, int len, int dominant_pct);
    logic [15:0] alphabet[3];
    for (int k = 0; k < 3; k++) alphabet[k] = 16'($urandom);
    for (int i = base; i < base + len; i++)
      add_write(i, ($urandom_range(99) < dominant_pct) ? alphabet[0]
                                                       : alphabet[$urandom_range(2)]);
  endtask

  // Accepted items update the local copy of the block and queue their answers.
  always @(posedge clk) begin
    if (rst_n && in_push && !in_full) begin
      if (in_cmd == CMD_WRITE)
        store_value(in_first_index, in_new_value);
      else
        answers.push_back(answer_range(in_first_index, in_last_index));
      void'(requests.pop_front());
      accepted_items <= accepted_items + 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (requests.size() > 0 &&
                 ((accepted_items >= 300 && accepted_items < 380) ||
                  $urandom_range(99) >= 36)) begin
      in_push <= 1'b1;
      in_cmd <= requests[0].cmd;
      in_first_index <= requests[0].first;
      in_last_index <= requests[0].last;
      in_new_value <= requests[0].value;
    end else begin
      in_push <= 1'b0;
    end
  end

  // The receiver stops once for a long stretch so that the block backs up.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_pop <= 1'b0;
    end else if (!stall_done && popped_results == 20) begin
      stall_done = 1;
      stall_left = 2000;
      out_pop <= 1'b0;
    end else begin
      out_pop <= (popped_results >= 100 && popped_results < 150) || $urandom_range(99) >= 36;
    end
  end

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_pop && !out_empty) begin
      popped_results <= popped_results + 1;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = answers.pop_front();
        if (out_changes_needed !== e.changes || out_majority_found !== e.found ||
            out_majority_value !== e.value || out_majority_count !== e.count ||
            out_bad_range !== e.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch at %0t: exp chg=%0d fnd=%0b val=%h cnt=%0d bad=%0b,",
                      " got chg=%0d fnd=%0b val=%h cnt=%0d bad=%0b"},
                     $realtime, e.changes, e.found, e.value, e.count, e.bad,
                     out_changes_needed, out_majority_found, out_majority_value,
                     out_majority_count, out_bad_range);
        end
      end
    end
  end

  initial begin
    int len;
    int base;
    int f;
    int l;
    for (int n = 0; n < 2*NPOS; n++) shadow_tree[n] = '0;
    for (int i = 0; i < NPOS; i++) begin
      shadow_store[i] = '0;
      gen_written[i] = 0;
    end

    // Directed: field extremes, ties, clean majorities and empty ranges.
    add_write(0, 16'h0000);
    add_write(1, 16'hFFFF);
    add_write(1023, 16'hAAAA);
    add_write(1022, 16'h5555);
    add_write(512, 16'd7);
    add_write(513, 16'd7);
    add_write(514, 16'd7);
    add_write(515, 16'd9);
    add_query(0, 0);
    add_query(0, 1);
    add_query(1023, 1023);
    add_query(1022, 1023);
    add_query(512, 515);
    add_query(512, 513);
    add_query(513, 515);
    add_query(514, 515);
    add_query(5, 4);
    add_query(1023, 0);
    add_write(1023, 16'h5555);
    add_query(1022, 1023);

    while (requests.size() < 540) begin
      if (requests.size() > 250 && !gen_written[300]) begin
        // One long window so that a few queries scan hundreds of positions.
        add_window(200, 256, 80);
        add_query(200, 455);
        add_query(201, 455);
        add_query(250, 400);
      end else if ($urandom_range(99) < 75) begin
        len = $urandom_range(1, 24);
        base = $urandom_range(0, NPOS - len);
        add_window(base, len, $urandom_range(30, 90));
        repeat ($urandom_range(1, 4)) begin
          f = $urandom_range(base, base + len - 1);
          add_query(f, $urandom_range(f, base + len - 1));
        end
      end else if ($urandom_range(1)) begin
        f = $urandom_range(1, NPOS - 1);
        add_query(f, $urandom_range(0, f - 1));
      end else if ($urandom_range(1)) begin
        add_write($urandom_range(0, NPOS - 1), 16'($urandom));
      end else begin
        // A range of up to 41 written positions, stopping at the first unwritten position.
        f = $urandom_range(0, NPOS - 1);
        if (gen_written[f]) begin
          l = f;
          len = $urandom_range(0, 40);
          while (l < NPOS - 1 && gen_written[l+1] && l - f < len) l++;
          add_query(f, l);
        end
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (requests.size() > 0 || answers.size() > 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (mismatches == 0 && answers.size() == 0) begin
      $display("range_majority_segment_tree_tb OK");
    end else begin
      $display("range_majority_segment_tree_tb NOT OK");
    end
    $finish;
  end

endmodule
